// ----- rtl/dchs_pkg.sv -----
`default_nettype none

package dchs_pkg;

  // field widths
  localparam int unsigned BYTES_W = 41;
  localparam int unsigned CYL_W   = 16;
  localparam int unsigned HEAD_W  = 5;
  localparam int unsigned SPT_W   = 8;

  // sector count after clamp fits in 28 bits
  localparam int unsigned SECT_W  = 28;
  localparam int unsigned SECTOR_SHIFT = 9;

  localparam logic [SECT_W-1:0] MAX_SECTORS = SECT_W'(64'd65535 * 64'd16 * 64'd255);
  localparam logic [SECT_W-1:0] BIG_SECTORS = SECT_W'(64'd65535 * 64'd16 * 64'd63);

  // sectors-per-track codes
  localparam logic [SPT_W-1:0] SPT_17  = 8'd17;
  localparam logic [SPT_W-1:0] SPT_31  = 8'd31;
  localparam logic [SPT_W-1:0] SPT_63  = 8'd63;
  localparam logic [SPT_W-1:0] SPT_255 = 8'd255;

  localparam logic [HEAD_W-1:0] HEADS_MIN = 5'd4;
  localparam logic [HEAD_W-1:0] HEADS_MAX = 5'd16;

  // reciprocal constants for the divide by sectors-per-track
  localparam int unsigned RECIP_W  = 30;
  localparam int unsigned SHIFT17  = 33;
  localparam int unsigned SHIFT31  = 33;
  localparam int unsigned SHIFT63  = 34;
  localparam int unsigned SHIFT255 = 36;
  localparam logic [RECIP_W-1:0] RECIP17  =
    RECIP_W'(((64'd1 << SHIFT17) + 64'd16) / 64'd17);
  localparam logic [RECIP_W-1:0] RECIP31  =
    RECIP_W'(((64'd1 << SHIFT31) + 64'd30) / 64'd31);
  localparam logic [RECIP_W-1:0] RECIP63  =
    RECIP_W'(((64'd1 << SHIFT63) + 64'd62) / 64'd63);
  localparam logic [RECIP_W-1:0] RECIP255 =
    RECIP_W'(((64'd1 << SHIFT255) + 64'd254) / 64'd255);

  // quotient widths
  localparam int unsigned Q17_W  = 24;
  localparam int unsigned Q31_W  = 23;
  localparam int unsigned Q63_W  = 22;
  localparam int unsigned Q255_W = 20;

  // cylinders-times-heads after selection
  localparam int unsigned CTH_W      = 20;
  localparam int unsigned CTH_LO_W   = 14;
  localparam int unsigned TRACK_LIM  = 16384;

  // reciprocal of the head count, scaled by 2^19
  localparam int unsigned HRECIP_W     = 18;
  localparam int unsigned HRECIP_SHIFT = 19;

  typedef struct packed {
    logic [Q17_W-1:0]  q17;
    logic [Q31_W-1:0]  q31;
    logic [Q63_W-1:0]  q63;
    logic [Q255_W-1:0] q255;
    logic              big;
  } dchs_quot_t;

  typedef struct packed {
    logic [CTH_W-1:0]  cth;
    logic [HEAD_W-1:0] heads;
    logic [SPT_W-1:0]  spt;
  } dchs_sel_t;

  function automatic logic [HRECIP_W-1:0] head_recip(input logic [HEAD_W-1:0] h);
    logic [HRECIP_W-1:0] r;
    case (h)
      5'd4:    r = 18'd131072;
      5'd5:    r = 18'd104858;
      5'd6:    r = 18'd87382;
      5'd7:    r = 18'd74899;
      5'd8:    r = 18'd65536;
      5'd9:    r = 18'd58255;
      5'd10:   r = 18'd52429;
      5'd11:   r = 18'd47663;
      5'd12:   r = 18'd43691;
      5'd13:   r = 18'd40330;
      5'd14:   r = 18'd37450;
      5'd15:   r = 18'd34953;
      5'd16:   r = 18'd32768;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/disk_chs_geometry.sv -----
`default_nettype none

// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------------
// in       | input     | in_valid_i/in_ready_o | disk_bytes_i (41b)
// out      | output    | out_valid_o/out_ready_i | cylinder_count_o, head_count_o,
//          |           |                       | sectors_per_track_o
//
// one word in per cycle, one word out per cycle, while the output does not stall;
// each word passes through four register stages in turn
// (clamp, constant divides, geometry select, head divide with output register)
// the four sector-per-track divides share one stage, set by its multipliers
// reset clears only the stage valid bits; data registers hold no reset
// a stall on the output holds every full stage; bubbles still close up

module disk_chs_geometry (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dchs_pkg::BYTES_W-1:0]  disk_bytes_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dchs_pkg::CYL_W-1:0]         cylinder_count_o,
  output logic [dchs_pkg::HEAD_W-1:0]        head_count_o,
  output logic [dchs_pkg::SPT_W-1:0]         sectors_per_track_o
);

  // stage links
  logic                  div_valid, div_ready;
  dchs_pkg::dchs_quot_t  div_quot;
  logic                  sel_valid, sel_ready;
  dchs_pkg::dchs_sel_t   sel_word;

  // sector count, clamp and the divides by 17, 31, 63 and 255
  dchs_divide u_divide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .disk_bytes_i (disk_bytes_i),
    .valid_o      (div_valid),
    .ready_i      (div_ready),
    .quot_o       (div_quot)
  );

  // pick sectors per track and heads: 255 for big disks, else falling back 17 -> 31 -> 63
  dchs_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (div_ready),
    .quot_i  (div_quot),
    .valid_o (sel_valid),
    .ready_i (sel_ready),
    .sel_o   (sel_word)
  );

  // cylinders = cth / heads, registered as the result word
  dchs_cyl u_cyl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (sel_valid),
    .ready_o             (sel_ready),
    .sel_i               (sel_word),
    .valid_o             (out_valid_o),
    .ready_i             (out_ready_i),
    .cylinder_count_o    (cylinder_count_o),
    .head_count_o        (head_count_o),
    .sectors_per_track_o (sectors_per_track_o)
  );

endmodule

`default_nettype wire

// ----- rtl/dchs_divide.sv -----
`default_nettype none

module dchs_divide (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  output logic                                   ready_o,
  input  wire logic [dchs_pkg::BYTES_W-1:0]      disk_bytes_i,
  output logic                                   valid_o,
  input  wire logic                              ready_i,
  output dchs_pkg::dchs_quot_t                   quot_o
);

  localparam int unsigned PROD_W = dchs_pkg::SECT_W + dchs_pkg::RECIP_W;

  logic                          v1_q, v2_q;
  logic                          en1, en2;
  logic [dchs_pkg::SECT_W-1:0]   sect_d, sect_q;
  logic [dchs_pkg::BYTES_W-dchs_pkg::SECTOR_SHIFT-1:0] raw_sect;
  logic [PROD_W-1:0]             p17, p31, p63, p255;
  dchs_pkg::dchs_quot_t          quot_d, quot_q;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  // sector count with clamp
  assign raw_sect = disk_bytes_i[dchs_pkg::BYTES_W-1:dchs_pkg::SECTOR_SHIFT];
  always_comb begin
    if (raw_sect > {4'd0, dchs_pkg::MAX_SECTORS}) begin
      sect_d = dchs_pkg::MAX_SECTORS;
    end else begin
      sect_d = raw_sect[dchs_pkg::SECT_W-1:0];
    end
  end

  // four constant divides in parallel
  assign p17  = PROD_W'(sect_q) * PROD_W'(dchs_pkg::RECIP17);
  assign p31  = PROD_W'(sect_q) * PROD_W'(dchs_pkg::RECIP31);
  assign p63  = PROD_W'(sect_q) * PROD_W'(dchs_pkg::RECIP63);
  assign p255 = PROD_W'(sect_q) * PROD_W'(dchs_pkg::RECIP255);

  always_comb begin
    quot_d.q17  = p17[dchs_pkg::SHIFT17 +: dchs_pkg::Q17_W];
    quot_d.q31  = p31[dchs_pkg::SHIFT31 +: dchs_pkg::Q31_W];
    quot_d.q63  = p63[dchs_pkg::SHIFT63 +: dchs_pkg::Q63_W];
    quot_d.q255 = p255[dchs_pkg::SHIFT255 +: dchs_pkg::Q255_W];
    quot_d.big  = (sect_q >= dchs_pkg::BIG_SECTORS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) sect_q <= sect_d;
    if (en2 && v1_q)    quot_q <= quot_d;
  end

  assign valid_o = v2_q;
  assign quot_o  = quot_q;

endmodule

`default_nettype wire

// ----- rtl/dchs_select.sv -----
`default_nettype none

module dchs_select (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire dchs_pkg::dchs_quot_t quot_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output dchs_pkg::dchs_sel_t       sel_o
);

  localparam int unsigned SUM_W = dchs_pkg::Q17_W + 1;
  localparam int unsigned HC_W  = SUM_W - 10;

  logic                  v_q, en;
  logic [SUM_W-1:0]      sum17;
  logic [HC_W-1:0]       hc, h17;
  logic                  fail17, fail31;
  dchs_pkg::dchs_sel_t   sel_d, sel_q;

  assign en      = !v_q || ready_i;
  assign ready_o = en;

  // heads for 17 sectors: ceil(cth / 1024), at least four
  assign sum17 = SUM_W'(quot_i.q17) + SUM_W'(1023);
  assign hc    = sum17[SUM_W-1:10];
  assign h17   = (hc < HC_W'(dchs_pkg::HEADS_MIN)) ? HC_W'(dchs_pkg::HEADS_MIN) : hc;

  assign fail17 = (SUM_W'(quot_i.q17) >= {h17, 10'd0}) ||
                  (h17 > HC_W'(dchs_pkg::HEADS_MAX));
  assign fail31 = (quot_i.q31 >= dchs_pkg::Q31_W'(dchs_pkg::TRACK_LIM));

  always_comb begin
    if (quot_i.big) begin
      sel_d.spt   = dchs_pkg::SPT_255;
      sel_d.heads = dchs_pkg::HEADS_MAX;
      sel_d.cth   = quot_i.q255;
    end else if (!fail17) begin
      sel_d.spt   = dchs_pkg::SPT_17;
      sel_d.heads = h17[dchs_pkg::HEAD_W-1:0];
      sel_d.cth   = dchs_pkg::CTH_W'(quot_i.q17[dchs_pkg::CTH_LO_W-1:0]);
    end else if (!fail31) begin
      sel_d.spt   = dchs_pkg::SPT_31;
      sel_d.heads = dchs_pkg::HEADS_MAX;
      sel_d.cth   = dchs_pkg::CTH_W'(quot_i.q31[dchs_pkg::CTH_LO_W-1:0]);
    end else begin
      // below the big-disk bound so the quotient fits 20 bits
      sel_d.spt   = dchs_pkg::SPT_63;
      sel_d.heads = dchs_pkg::HEADS_MAX;
      sel_d.cth   = quot_i.q63[dchs_pkg::CTH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) sel_q <= sel_d;
  end

  assign valid_o = v_q;
  assign sel_o   = sel_q;

endmodule

`default_nettype wire

// ----- rtl/dchs_cyl.sv -----
`default_nettype none

module dchs_cyl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire dchs_pkg::dchs_sel_t           sel_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic [dchs_pkg::CYL_W-1:0]         cylinder_count_o,
  output logic [dchs_pkg::HEAD_W-1:0]        head_count_o,
  output logic [dchs_pkg::SPT_W-1:0]         sectors_per_track_o
);

  localparam int unsigned PROD_W = dchs_pkg::CTH_LO_W + dchs_pkg::HRECIP_W;

  logic                          v_q, en;
  logic [PROD_W-1:0]             prod;
  logic [dchs_pkg::CYL_W-1:0]    cyl_d, cyl_q;
  logic [dchs_pkg::HEAD_W-1:0]   heads_q;
  logic [dchs_pkg::SPT_W-1:0]    spt_q;

  assign en      = !v_q || ready_i;
  assign ready_o = en;

  // divide by head count through a scaled reciprocal, exact for cth below 2^14
  assign prod = PROD_W'(sel_i.cth[dchs_pkg::CTH_LO_W-1:0]) *
                PROD_W'(dchs_pkg::head_recip(sel_i.heads));

  always_comb begin
    if (sel_i.heads == dchs_pkg::HEADS_MAX) begin
      cyl_d = sel_i.cth[dchs_pkg::CTH_W-1:4];
    end else begin
      cyl_d = dchs_pkg::CYL_W'(prod[PROD_W-1:dchs_pkg::HRECIP_SHIFT]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      cyl_q   <= cyl_d;
      heads_q <= sel_i.heads;
      spt_q   <= sel_i.spt;
    end
  end

  assign valid_o             = v_q;
  assign cylinder_count_o    = cyl_q;
  assign head_count_o        = heads_q;
  assign sectors_per_track_o = spt_q;

endmodule

`default_nettype wire

// ----- tb/sv/geometry_checker.sv -----
`default_nettype none

module geometry_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic [dchs_pkg::BYTES_W-1:0]  disk_bytes_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [dchs_pkg::CYL_W-1:0]    cylinder_count_i,
  input  wire logic [dchs_pkg::HEAD_W-1:0]   head_count_i,
  input  wire logic [dchs_pkg::SPT_W-1:0]    sectors_per_track_i,
  output logic [31:0]                        fail_count_o,
  output logic [31:0]                        pending_o
);

  typedef struct packed {
    logic [dchs_pkg::CYL_W-1:0]  cyl;
    logic [dchs_pkg::HEAD_W-1:0] heads;
    logic [dchs_pkg::SPT_W-1:0]  spt;
  } chs_t;

  localparam longint unsigned SECTOR_CAP   = 64'd65535 * 64'd16 * 64'd255;
  localparam longint unsigned BIG_DISK_MIN = 64'd65535 * 64'd16 * 64'd63;
  localparam longint unsigned CYLS_PER_HEAD = 64'd1024;

  chs_t        geom_q[$];
  int unsigned mismatches;

  initial begin
    mismatches   = 0;
    fail_count_o = '0;
    pending_o    = '0;
  end

  function automatic chs_t calc_geometry(input logic [dchs_pkg::BYTES_W-1:0] bytes);
    longint unsigned sect;
    longint unsigned cth;
    longint unsigned heads;
    longint unsigned spt;
    chs_t            g;
    sect = longint'(bytes) >> dchs_pkg::SECTOR_SHIFT;
    if (sect > SECTOR_CAP) sect = SECTOR_CAP;
    if (sect >= BIG_DISK_MIN) begin
      spt   = dchs_pkg::SPT_255;
      heads = dchs_pkg::HEADS_MAX;
      cth   = sect / spt;
    end else begin
      spt   = dchs_pkg::SPT_17;
      cth   = sect / spt;
      heads = (cth + CYLS_PER_HEAD - 1) / CYLS_PER_HEAD;
      if (heads < dchs_pkg::HEADS_MIN) heads = dchs_pkg::HEADS_MIN;
      if (cth >= heads * CYLS_PER_HEAD || heads > dchs_pkg::HEADS_MAX) begin
        spt   = dchs_pkg::SPT_31;
        heads = dchs_pkg::HEADS_MAX;
        cth   = sect / spt;
      end
      if (cth >= heads * CYLS_PER_HEAD) begin
        spt   = dchs_pkg::SPT_63;
        heads = dchs_pkg::HEADS_MAX;
        cth   = sect / spt;
      end
    end
    g.cyl   = dchs_pkg::CYL_W'(cth / heads);
    g.heads = dchs_pkg::HEAD_W'(heads);
    g.spt   = dchs_pkg::SPT_W'(spt);
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches   = mismatches + 1;
    fail_count_o = mismatches;
  endtask

  always @(posedge clk_i) begin : watch
    chs_t want;
    if (rst_ni) begin
      // retire the result word first, then queue the new size word
      if (out_valid_i && out_ready_i) begin
        if (geom_q.size() == 0) begin
          report_mismatch("unexpected word, cylinders", cylinder_count_i, 0);
        end else begin
          want = geom_q.pop_front();
          if (cylinder_count_i !== want.cyl)
            report_mismatch("cylinders", cylinder_count_i, want.cyl);
          if (head_count_i !== want.heads)
            report_mismatch("heads", head_count_i, want.heads);
          if (sectors_per_track_i !== want.spt)
            report_mismatch("sectors per track", sectors_per_track_i, want.spt);
        end
      end
      if (in_valid_i && in_ready_i)
        geom_q.push_back(calc_geometry(disk_bytes_i));
      pending_o <= geom_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;

  localparam int unsigned RANDOM_WORDS = 1450;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned BURST_WORDS  = 60;
  localparam int unsigned SETTLE_CYCLES = 12;

  // sector boundaries used to steer the random sizes
  localparam longint unsigned TRACK_17   = dchs_pkg::SPT_17;
  localparam longint unsigned TRACK_31   = dchs_pkg::SPT_31;
  localparam longint unsigned TRACK_63   = dchs_pkg::SPT_63;
  localparam longint unsigned CYLS_HEAD  = 1024;
  localparam longint unsigned BIG_MIN    = dchs_pkg::BIG_SECTORS;
  localparam longint unsigned SECT_CAP   = dchs_pkg::MAX_SECTORS;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [dchs_pkg::BYTES_W-1:0]  disk_bytes_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [dchs_pkg::CYL_W-1:0]    cylinder_count_o;
  logic [dchs_pkg::HEAD_W-1:0]   head_count_o;
  logic [dchs_pkg::SPT_W-1:0]    sectors_per_track_o;
  logic [31:0]                   fail_count;
  logic [31:0]                   pending_words;

  // set by the sender to ask the receiver for one long hold-off, cleared by it
  bit                            hold_off_req;
  int unsigned                   cycle_count;

  disk_chs_geometry uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .disk_bytes_i        (disk_bytes_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .cylinder_count_o    (cylinder_count_o),
    .head_count_o        (head_count_o),
    .sectors_per_track_o (sectors_per_track_o)
  );

  geometry_checker checker_i (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .disk_bytes_i        (disk_bytes_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .cylinder_count_i    (cylinder_count_o),
    .head_count_i        (head_count_o),
    .sectors_per_track_i (sectors_per_track_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending_words)
  );

  // two time unit clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog: a hang anywhere ends the run as a failure
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // byte count from a sector count plus a partial sector tail
  function automatic logic [dchs_pkg::BYTES_W-1:0] sect_to_bytes(
    input longint unsigned sect, input int unsigned tail);
    return dchs_pkg::BYTES_W'((sect << dchs_pkg::SECTOR_SHIFT) + tail);
  endfunction

  // random size, weighted toward the interesting geometry regions
  function automatic logic [dchs_pkg::BYTES_W-1:0] pick_disk_bytes();
    logic [63:0]     raw;
    longint unsigned sect;
    longint unsigned spt;
    int unsigned     kind;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      // anywhere in the field, mostly saturating
      raw = {$urandom(), $urandom()};
      return raw[dchs_pkg::BYTES_W-1:0];
    end
    if (kind < 35)      sect = $urandom_range(0, TRACK_17 * CYLS_HEAD * 8);
    else if (kind < 50) sect = $urandom_range(0, TRACK_17 * CYLS_HEAD * 16 + 1000);
    else if (kind < 65) sect = $urandom_range(TRACK_17 * CYLS_HEAD * 16, BIG_MIN - 1);
    else if (kind < 80) sect = $urandom_range(BIG_MIN - 1000, SECT_CAP + 100000);
    else begin
      // around a cylinder-per-head boundary of one of the small track sizes
      case ($urandom_range(0, 2))
        0:       spt = TRACK_17;
        1:       spt = TRACK_31;
        default: spt = TRACK_63;
      endcase
      sect = spt * CYLS_HEAD * $urandom_range(4, 16) - spt + $urandom_range(0, 2 * spt);
    end
    return sect_to_bytes(sect, $urandom_range(0, 511));
  endfunction

  // offer one size word after an optional idle gap, return once accepted
  task automatic offer_disk(input logic [dchs_pkg::BYTES_W-1:0] bytes,
                            input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    disk_bytes_i <= bytes;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // sender: reset, directed corners, random words with pressure points, verdict
  initial begin : sender
    logic [dchs_pkg::BYTES_W-1:0] corner_q[$];
    int unsigned                  calm_left;
    int unsigned                  burst_left;
    int unsigned                  gap;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    disk_bytes_i = '0;
    hold_off_req = 1'b0;
    calm_left    = 0;
    burst_left   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty disk, partial sector, one track
    corner_q.push_back('0);
    corner_q.push_back(sect_to_bytes(0, 511));
    corner_q.push_back(sect_to_bytes(16, 511));
    corner_q.push_back(sect_to_bytes(TRACK_17, 0));
    // 17 sectors with 4 heads and the head-count steps
    corner_q.push_back(sect_to_bytes(TRACK_17 * CYLS_HEAD * 4 - 1, 0));
    corner_q.push_back(sect_to_bytes(TRACK_17 * CYLS_HEAD * 4, 0));
    corner_q.push_back(sect_to_bytes(TRACK_17 * (CYLS_HEAD * 4 + 1), 0));
    corner_q.push_back(sect_to_bytes(TRACK_17 * CYLS_HEAD * 5 - 1, 511));
    corner_q.push_back(sect_to_bytes(TRACK_17 * CYLS_HEAD * 5, 0));
    // fall back to 31 and then 63 sectors per track
    corner_q.push_back(sect_to_bytes(TRACK_17 * CYLS_HEAD * 16 - 1, 0));
    corner_q.push_back(sect_to_bytes(TRACK_17 * CYLS_HEAD * 16, 0));
    corner_q.push_back(sect_to_bytes(TRACK_17 * (CYLS_HEAD * 16 + 1), 0));
    corner_q.push_back(sect_to_bytes(TRACK_31 * CYLS_HEAD * 16 - 1, 0));
    corner_q.push_back(sect_to_bytes(TRACK_31 * CYLS_HEAD * 16, 0));
    corner_q.push_back(sect_to_bytes(TRACK_63 * CYLS_HEAD * 16 - 1, 0));
    corner_q.push_back(sect_to_bytes(TRACK_63 * CYLS_HEAD * 16, 0));
    // 255 sectors per track threshold and saturation
    corner_q.push_back(sect_to_bytes(BIG_MIN - 1, 511));
    corner_q.push_back(sect_to_bytes(BIG_MIN, 0));
    corner_q.push_back(sect_to_bytes(SECT_CAP - 1, 0));
    corner_q.push_back(sect_to_bytes(SECT_CAP, 0));
    corner_q.push_back(sect_to_bytes(SECT_CAP + 1, 0));
    // every input bit high, then alternating bit patterns
    corner_q.push_back('1);
    corner_q.push_back(41'h155_5555_5555);
    corner_q.push_back(41'h0AA_AAAA_AAAA);
    foreach (corner_q[i]) offer_disk(corner_q[i], pick_gap());

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      // one long receiver hold-off while words keep coming back to back
      if (n == 400) begin
        hold_off_req = 1'b1;
        burst_left   = BURST_WORDS;
      end
      // one full drain with the input idle
      if (n == 900) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_words != 0) @(posedge clk_i);
      end
      // occasional stretches with no idling at all
      if (calm_left == 0 && $urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
      if (burst_left > 0) begin
        gap        = 0;
        burst_left = burst_left - 1;
      end else if (calm_left > 0) begin
        gap       = 0;
        calm_left = calm_left - 1;
      end else begin
        gap = pick_gap();
      end
      offer_disk(pick_disk_bytes(), gap);
    end

    // wait for every result, then let the bench settle to catch any stray words
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: random back-pressure, steady stretches, one long hold-off
  initial begin : receiver
    int unsigned busy;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk_i);
      end else begin
        busy = pick_gap();
        if (busy > 0) begin
          out_ready_i <= 1'b0;
          repeat (busy) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

endmodule

`default_nettype wire
